[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer package
// Beat types, control byte codes and the microcode table of the sequencer.
// ----------------------------------------------------------------------------

package tcw_pkg;

    typedef logic [10:0] t_cell_idx;
    typedef logic [6:0]  t_col_field;
    typedef logic [4:0]  t_row_field;
    typedef logic [4:0]  t_upc;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        t_cell_idx  cell_address;
    } t_in_beat;

    typedef struct packed {
        t_cell_idx  cursor_position;
        t_col_field cursor_column;
        t_row_field cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       escape_pending;
    } t_out_beat;

    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ESC   = 8'h1b;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam logic [7:0] CMD_END    = 8'd0;
    localparam logic [7:0] CMD_ATTR   = 8'd1;
    localparam logic [7:0] CMD_COLUMN = 8'd2;
    localparam logic [7:0] CMD_ROW    = 8'd3;

    typedef enum logic [1:0] {
        ESC_IDLE     = 2'd0,
        ESC_WAIT_CMD = 2'd1,
        ESC_WAIT_ARG = 2'd2
    } t_esc_phase;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_CELL,
        MEM_RD_BELOW,
        MEM_WR_COPY,
        MEM_WR_BLANK_PTR,
        MEM_WR_CHAR_CUR,
        MEM_WR_BLANK_CUR
    } t_mem_op;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_COL0,
        CUR_BACK,
        CUR_ADV,
        CUR_DOWN
    } t_cur_op;

    typedef enum logic [2:0] {
        EOP_HOLD,
        EOP_IDLE,
        EOP_START,
        EOP_CMD,
        EOP_ARG
    } t_esc_op;

    typedef enum logic [2:0] {
        SEQ_WAIT,
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_BRANCH,
        SEQ_FINISH,
        SEQ_FINISH_UNLESS
    } t_seq_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_CLR_MORE,
        COND_COPY_MORE,
        COND_COL_LAST,
        COND_ROW_LAST,
        COND_NO_ITEM
    } t_cond;

    typedef struct packed {
        t_mem_op mem;
        t_ptr_op ptr;
        t_cur_op cur;
        t_esc_op esc;
        t_seq_op seq;
        t_cond   cond;
        t_upc    target;
    } t_uword;

    localparam t_upc U_IDLE     = 5'd0;
    localparam t_upc U_READ     = 5'd1;
    localparam t_upc U_DONE     = 5'd2;
    localparam t_upc U_CR       = 5'd3;
    localparam t_upc U_ESC      = 5'd4;
    localparam t_upc U_ESC_CMD  = 5'd5;
    localparam t_upc U_ESC_ARG  = 5'd6;
    localparam t_upc U_BS       = 5'd7;
    localparam t_upc U_BS_WR    = 5'd8;
    localparam t_upc U_CHAR     = 5'd9;
    localparam t_upc U_LF       = 5'd10;
    localparam t_upc U_SCR      = 5'd11;
    localparam t_upc U_SCR_RD   = 5'd12;
    localparam t_upc U_SCR_WR   = 5'd13;
    localparam t_upc U_CLR      = 5'd14;
    localparam t_upc U_CLR_END  = 5'd15;
    localparam t_upc U_BOOT_END = 5'd16;
    localparam t_upc U_FF       = 5'd17;

    function automatic t_uword uw(t_mem_op m, t_ptr_op p, t_cur_op c, t_esc_op e,
                                  t_seq_op s, t_cond k, t_upc t);
        t_uword w;
        w.mem    = m;
        w.ptr    = p;
        w.cur    = c;
        w.esc    = e;
        w.seq    = s;
        w.cond   = k;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword ucode_rom(t_upc a);
        t_uword w;
        case (a)
            U_IDLE:     w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_WAIT, COND_NONE, U_IDLE);
            U_READ:     w = uw(MEM_RD_CELL, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_NEXT, COND_NONE, U_IDLE);
            U_DONE:     w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_FINISH, COND_NONE, U_IDLE);
            U_CR:       w = uw(MEM_NONE, PTR_HOLD, CUR_COL0, EOP_IDLE,
                               SEQ_FINISH, COND_NONE, U_IDLE);
            U_ESC:      w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_START,
                               SEQ_FINISH, COND_NONE, U_IDLE);
            U_ESC_CMD:  w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_CMD,
                               SEQ_FINISH, COND_NONE, U_IDLE);
            U_ESC_ARG:  w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_ARG,
                               SEQ_FINISH, COND_NONE, U_IDLE);
            U_BS:       w = uw(MEM_NONE, PTR_HOLD, CUR_BACK, EOP_IDLE,
                               SEQ_NEXT, COND_NONE, U_IDLE);
            U_BS_WR:    w = uw(MEM_WR_BLANK_CUR, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_FINISH, COND_NONE, U_IDLE);
            U_CHAR:     w = uw(MEM_WR_CHAR_CUR, PTR_HOLD, CUR_ADV, EOP_IDLE,
                               SEQ_FINISH_UNLESS, COND_COL_LAST, U_IDLE);
            U_LF:       w = uw(MEM_NONE, PTR_HOLD, CUR_DOWN, EOP_IDLE,
                               SEQ_FINISH_UNLESS, COND_ROW_LAST, U_IDLE);
            U_SCR:      w = uw(MEM_NONE, PTR_ZERO, CUR_HOLD, EOP_HOLD,
                               SEQ_NEXT, COND_NONE, U_IDLE);
            U_SCR_RD:   w = uw(MEM_RD_BELOW, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_NEXT, COND_NONE, U_IDLE);
            U_SCR_WR:   w = uw(MEM_WR_COPY, PTR_INC, CUR_HOLD, EOP_HOLD,
                               SEQ_BRANCH, COND_COPY_MORE, U_SCR_RD);
            U_CLR:      w = uw(MEM_WR_BLANK_PTR, PTR_INC, CUR_HOLD, EOP_HOLD,
                               SEQ_BRANCH, COND_CLR_MORE, U_CLR);
            U_CLR_END:  w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_FINISH_UNLESS, COND_NO_ITEM, U_IDLE);
            U_BOOT_END: w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_GOTO, COND_NONE, U_IDLE);
            U_FF:       w = uw(MEM_NONE, PTR_ZERO, CUR_HOME, EOP_IDLE,
                               SEQ_GOTO, COND_NONE, U_CLR);
            default:    w = uw(MEM_NONE, PTR_HOLD, CUR_HOLD, EOP_HOLD,
                               SEQ_GOTO, COND_NONE, U_IDLE);
        endcase
        return w;
    endfunction

    function automatic t_upc dispatch(logic operation, logic [7:0] ch, t_esc_phase ph);
        t_upc a;
        if (operation) begin
            a = U_READ;
        end else if (ph == ESC_WAIT_CMD) begin
            a = U_ESC_CMD;
        end else if (ph == ESC_WAIT_ARG) begin
            a = U_ESC_ARG;
        end else begin
            case (ch)
                CHAR_FF:  a = U_FF;
                CHAR_CR:  a = U_CR;
                CHAR_BS:  a = U_BS;
                CHAR_LF:  a = U_LF;
                CHAR_ESC: a = U_ESC;
                default:  a = U_CHAR;
            endcase
        end
        return a;
    endfunction

endpackage

[hdl/text_console_character_writer.sv]
// Reads, backspace and line wrap pass through more control steps than printable bytes,
// carriage return, line feed without scroll and escape bytes.
// A scroll copies the rows up and blanks the last row, and a form feed blanks every cell,
// through the single write and read port of the screen memory. One item at a time.
// After reset the memory is swept to blanks with input stalled.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer
// Microcoded text screen: a step counter walks a control table that drives the
// cursor, escape and pointer registers and the screen memory.
// ----------------------------------------------------------------------------

module text_console_character_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcw_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcw_pkg::t_out_beat o_out_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    logic [15:0] r_screen [CELLS];
    logic [15:0] r_rdata;

    tcw_pkg::t_upc       r_upc,       n_upc;
    logic [AW-1:0]       r_ptr,       n_ptr;
    logic [CW-1:0]       r_col,       n_col;
    logic [RW-1:0]       r_row,       n_row;
    logic [7:0]          r_attr,      n_attr;
    tcw_pkg::t_esc_phase r_esc,       n_esc;
    logic [7:0]          r_cmd,       n_cmd;
    logic                r_item,      n_item;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_char,      n_char;
    logic [AW-1:0]       r_rd_addr,   n_rd_addr;
    logic                r_rd_ok,     n_rd_ok;
    tcw_pkg::t_out_beat  r_out_data,  n_out_data;

    tcw_pkg::t_uword     uw;
    logic                cond;
    logic                finishing;
    logic                go;
    logic [AW-1:0]       cur_idx;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [15:0]         mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    always_comb begin
        uw      = tcw_pkg::ucode_rom(r_upc);
        cur_idx = AW'(32'(r_row) * COLUMNS + 32'(r_col));

        case (uw.cond)
            tcw_pkg::COND_CLR_MORE:  cond = (r_ptr != AW'(CELLS - 1));
            tcw_pkg::COND_COPY_MORE: cond = (r_ptr != AW'(CELLS - COLUMNS - 1));
            tcw_pkg::COND_COL_LAST:  cond = (r_col == CW'(COLUMNS - 1));
            tcw_pkg::COND_ROW_LAST:  cond = (r_row == RW'(ROWS - 1));
            tcw_pkg::COND_NO_ITEM:   cond = !r_item;
            default:                 cond = 1'b0;
        endcase

        finishing = (uw.seq == tcw_pkg::SEQ_FINISH) ||
                    ((uw.seq == tcw_pkg::SEQ_FINISH_UNLESS) && !cond);
        go        = !(finishing && r_out_valid && i_out_stall);

        n_upc       = r_upc;
        n_ptr       = r_ptr;
        n_col       = r_col;
        n_row       = r_row;
        n_attr      = r_attr;
        n_esc       = r_esc;
        n_cmd       = r_cmd;
        n_item      = r_item;
        n_char      = r_char;
        n_rd_addr   = r_rd_addr;
        n_rd_ok     = r_rd_ok;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_wa      = r_ptr;
        mem_wd      = {r_attr, tcw_pkg::CHAR_SPACE};
        mem_re      = 1'b0;
        mem_ra      = r_rd_addr;

        if (go) begin
            case (uw.mem)
                tcw_pkg::MEM_RD_CELL: begin
                    mem_re = 1'b1;
                end
                tcw_pkg::MEM_RD_BELOW: begin
                    mem_re = 1'b1;
                    mem_ra = r_ptr + AW'(COLUMNS);
                end
                tcw_pkg::MEM_WR_COPY: begin
                    mem_we = 1'b1;
                    mem_wd = r_rdata;
                end
                tcw_pkg::MEM_WR_BLANK_PTR: begin
                    mem_we = 1'b1;
                end
                tcw_pkg::MEM_WR_CHAR_CUR: begin
                    mem_we = 1'b1;
                    mem_wa = cur_idx;
                    mem_wd = {r_attr, r_char};
                end
                tcw_pkg::MEM_WR_BLANK_CUR: begin
                    mem_we = 1'b1;
                    mem_wa = cur_idx;
                end
                default: begin
                end
            endcase

            case (uw.ptr)
                tcw_pkg::PTR_ZERO: n_ptr = '0;
                tcw_pkg::PTR_INC:  n_ptr = r_ptr + 1'b1;
                default:           n_ptr = r_ptr;
            endcase

            case (uw.cur)
                tcw_pkg::CUR_HOME: begin
                    n_col = '0;
                    n_row = '0;
                end
                tcw_pkg::CUR_COL0: begin
                    n_col = '0;
                end
                tcw_pkg::CUR_BACK: begin
                    if (r_col == '0) begin
                        n_col = CW'(COLUMNS - 1);
                        if (r_row != '0) begin
                            n_row = r_row - 1'b1;
                        end
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                end
                tcw_pkg::CUR_ADV: begin
                    n_col = (r_col == CW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
                end
                tcw_pkg::CUR_DOWN: begin
                    if (r_row != RW'(ROWS - 1)) begin
                        n_row = r_row + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            case (uw.esc)
                tcw_pkg::EOP_IDLE: begin
                    n_esc = tcw_pkg::ESC_IDLE;
                end
                tcw_pkg::EOP_START: begin
                    n_esc = tcw_pkg::ESC_WAIT_CMD;
                end
                tcw_pkg::EOP_CMD: begin
                    n_cmd = r_char;
                    n_esc = (r_char != tcw_pkg::CMD_END) ? tcw_pkg::ESC_WAIT_ARG
                                                         : tcw_pkg::ESC_IDLE;
                end
                tcw_pkg::EOP_ARG: begin
                    case (r_cmd)
                        tcw_pkg::CMD_ATTR: begin
                            n_attr = r_char;
                        end
                        tcw_pkg::CMD_COLUMN: begin
                            n_col = (32'(r_char) > COLUMNS - 1) ? CW'(COLUMNS - 1)
                                                                : CW'(r_char);
                        end
                        tcw_pkg::CMD_ROW: begin
                            n_row = (32'(r_char) > ROWS - 1) ? RW'(ROWS - 1)
                                                             : RW'(r_char);
                        end
                        default: begin
                        end
                    endcase
                    n_esc = tcw_pkg::ESC_IDLE;
                end
                default: begin
                end
            endcase

            case (uw.seq)
                tcw_pkg::SEQ_WAIT: begin
                    if (i_in_valid) begin
                        n_upc     = tcw_pkg::dispatch(i_in_data.operation,
                                                      i_in_data.char_code, r_esc);
                        n_item    = 1'b1;
                        n_char    = i_in_data.char_code;
                        n_rd_addr = AW'(i_in_data.cell_address);
                        n_rd_ok   = i_in_data.operation &&
                                    (32'(i_in_data.cell_address) < CELLS);
                    end
                end
                tcw_pkg::SEQ_NEXT:   n_upc = r_upc + 1'b1;
                tcw_pkg::SEQ_GOTO:   n_upc = uw.target;
                tcw_pkg::SEQ_BRANCH: n_upc = cond ? uw.target : r_upc + 1'b1;
                tcw_pkg::SEQ_FINISH_UNLESS: begin
                    if (cond) begin
                        n_upc = r_upc + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (finishing) begin
                n_upc                      = tcw_pkg::U_IDLE;
                n_item                     = 1'b0;
                n_out_valid                = 1'b1;
                n_out_data.cursor_position = tcw_pkg::t_cell_idx'(
                                                 32'(n_row) * COLUMNS + 32'(n_col));
                n_out_data.cursor_column   = tcw_pkg::t_col_field'(n_col);
                n_out_data.cursor_row      = tcw_pkg::t_row_field'(n_row);
                n_out_data.read_char       = r_rd_ok ? r_rdata[7:0] : 8'd0;
                n_out_data.read_attr       = r_rd_ok ? r_rdata[15:8] : 8'd0;
                n_out_data.escape_pending  = (n_esc == tcw_pkg::ESC_WAIT_CMD) ||
                                             (n_esc == tcw_pkg::ESC_WAIT_ARG);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= tcw_pkg::U_CLR;
            r_ptr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_esc       <= tcw_pkg::ESC_IDLE;
            r_cmd       <= tcw_pkg::CMD_END;
            r_item      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_ptr       <= n_ptr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_attr      <= n_attr;
            r_esc       <= n_esc;
            r_cmd       <= n_cmd;
            r_item      <= n_item;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_rd_addr  <= n_rd_addr;
        r_rd_ok    <= n_rd_ok;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_screen[mem_ra];
        end
    end

    assign o_in_stall  = (r_upc != tcw_pkg::U_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hdl/tcw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer checker
// Port-level properties of the console, bound to the top level.
// ----------------------------------------------------------------------------

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tcw_pkg::t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("Result beat changed while stalled.");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((32'(o_out_data.cursor_column) < COLUMNS) &&
                         (32'(o_out_data.cursor_row) < ROWS)))
        else $error("Cursor outside the screen.");

    a_cursor_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (COLUMNS <= 128) && (ROWS <= 32)) |->
        (o_out_data.cursor_position == tcw_pkg::t_cell_idx'(
            32'(o_out_data.cursor_row) * COLUMNS + 32'(o_out_data.cursor_column))))
        else $error("Cursor index does not match column and row.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input taken while an item is in progress.");

    a_boot_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input not stalled during the screen clear after reset.");

endmodule

bind text_console_character_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives put and read beats through the valid/stall handshake in random
// bursts and gaps, stalls the result side on changing patterns, and checks
// every result against a cycle-free model of the 80x25 screen. The model
// covers the cursor, the escape sequences, line wrap and scrolling.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int COLS       = 80;
    localparam int ROWS_N     = 25;
    localparam int CELL_COUNT = COLS * ROWS_N;
    localparam int RANDOM_KEYS = 600;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_AFTER_KEYS = 200;
    localparam int HOLD_CYCLES = 6000;
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct {
        tcw_pkg::t_in_beat beat;
        bit                drain_first;
    } t_key_req;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    tcw_pkg::t_in_beat  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tcw_pkg::t_out_beat out_data;

    t_key_req           keystroke_q[$];
    tcw_pkg::t_out_beat cursor_report_q[$];

    logic [15:0]         screen_copy [0:CELL_COUNT-1];
    int unsigned         cur_col;
    int unsigned         cur_row;
    logic [7:0]          cur_attr;
    tcw_pkg::t_esc_phase esc_ph;
    logic [7:0]          esc_cmd;

    int unsigned keys_taken = 0;
    int unsigned reports_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned total_keys = 0;
    int unsigned read_cnt = 0;
    int unsigned esc_cnt = 0;
    int unsigned scroll_cnt = 0;
    int unsigned clear_cnt = 0;

    int unsigned gap_left = 0;
    int unsigned burst_left = 4;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    logic        long_hold = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;

    text_console_character_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS_N)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void advance_row();
        int i;
        if (cur_row == ROWS_N - 1) begin
            for (i = 0; i < CELL_COUNT - COLS; i++) begin
                screen_copy[tcw_pkg::t_cell_idx'(i)] =
                    screen_copy[tcw_pkg::t_cell_idx'(i + COLS)];
            end
            for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
                screen_copy[tcw_pkg::t_cell_idx'(i)] = {cur_attr, tcw_pkg::CHAR_SPACE};
            end
            scroll_cnt++;
        end else begin
            cur_row++;
        end
    endfunction

    function automatic tcw_pkg::t_out_beat console_apply(tcw_pkg::t_in_beat b);
        tcw_pkg::t_out_beat r;
        int i;
        int unsigned c;
        r = '0;
        c = 32'(b.char_code);
        if (b.operation == OP_READ) begin
            if (b.cell_address < CELL_COUNT) begin
                r.read_char = screen_copy[b.cell_address][7:0];
                r.read_attr = screen_copy[b.cell_address][15:8];
            end
        end else if (esc_ph == tcw_pkg::ESC_WAIT_CMD) begin
            esc_cmd = b.char_code;
            esc_ph = (b.char_code != tcw_pkg::CMD_END) ? tcw_pkg::ESC_WAIT_ARG
                                                       : tcw_pkg::ESC_IDLE;
        end else if (esc_ph == tcw_pkg::ESC_WAIT_ARG) begin
            case (esc_cmd)
                tcw_pkg::CMD_ATTR:   cur_attr = b.char_code;
                tcw_pkg::CMD_COLUMN: cur_col = (c > COLS - 1) ? COLS - 1 : c;
                tcw_pkg::CMD_ROW:    cur_row = (c > ROWS_N - 1) ? ROWS_N - 1 : c;
                default:             ;
            endcase
            esc_ph = tcw_pkg::ESC_IDLE;
        end else begin
            case (b.char_code)
                tcw_pkg::CHAR_FF: begin
                    for (i = 0; i < CELL_COUNT; i++) begin
                        screen_copy[tcw_pkg::t_cell_idx'(i)] =
                            {cur_attr, tcw_pkg::CHAR_SPACE};
                    end
                    cur_col = 0;
                    cur_row = 0;
                    clear_cnt++;
                end
                tcw_pkg::CHAR_CR: cur_col = 0;
                tcw_pkg::CHAR_BS: begin
                    if (cur_col == 0) begin
                        cur_col = COLS - 1;
                        if (cur_row != 0) cur_row--;
                    end else begin
                        cur_col--;
                    end
                    screen_copy[tcw_pkg::t_cell_idx'(cur_row * COLS + cur_col)] =
                        {cur_attr, tcw_pkg::CHAR_SPACE};
                end
                tcw_pkg::CHAR_LF: advance_row();
                tcw_pkg::CHAR_ESC: esc_ph = tcw_pkg::ESC_WAIT_CMD;
                default: begin
                    screen_copy[tcw_pkg::t_cell_idx'(cur_row * COLS + cur_col)] =
                        {cur_attr, b.char_code};
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        advance_row();
                    end
                end
            endcase
        end
        r.cursor_position = tcw_pkg::t_cell_idx'(cur_row * COLS + cur_col);
        r.cursor_column   = tcw_pkg::t_col_field'(cur_col);
        r.cursor_row      = tcw_pkg::t_row_field'(cur_row);
        r.escape_pending  = (esc_ph == tcw_pkg::ESC_WAIT_CMD ||
                             esc_ph == tcw_pkg::ESC_WAIT_ARG);
        return r;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("Mismatch at report %0d: %s is %0h, expected %0h",
                 reports_seen, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic push_key(logic op, logic [7:0] ch, tcw_pkg::t_cell_idx addr);
        t_key_req k;
        k.beat.operation = op;
        k.beat.char_code = (op == OP_READ) ? 8'($urandom_range(0, 255)) : ch;
        k.beat.cell_address = (op == OP_READ) ? addr :
                              tcw_pkg::t_cell_idx'($urandom_range(0, 2047));
        k.drain_first = 1'b0;
        keystroke_q.push_back(k);
        if (op == OP_READ) read_cnt++;
        if (op == OP_PUT && ch == tcw_pkg::CHAR_ESC) esc_cnt++;
    endtask

    task automatic push_put(logic [7:0] ch);
        push_key(OP_PUT, ch, '0);
    endtask

    task automatic push_read(tcw_pkg::t_cell_idx addr);
        push_key(OP_READ, 8'h00, addr);
    endtask

    task automatic push_escape(logic [7:0] cmd, logic [7:0] arg);
        push_put(tcw_pkg::CHAR_ESC);
        push_put(cmd);
        if (cmd != tcw_pkg::CMD_END) push_put(arg);
    endtask

    // Sender: bursts of beats with random gaps, payload held while stalled.
    always @(posedge i_clk) begin : key_driver
        logic fire;
        logic offer;
        fire = in_valid && !in_stall;
        offer = in_valid && !fire;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (fire) begin
                cursor_report_q.push_back(console_apply(in_data));
                keys_taken <= keys_taken + 1;
            end
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (keystroke_q.size() != 0 && (!keystroke_q[0].drain_first ||
                             (!fire && keys_taken == reports_seen))) begin
                    in_data <= keystroke_q[0].beat;
                    keystroke_q.pop_front();
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(40, 80);
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 8);
                    end
                end
            end
            in_valid <= offer;
        end
    end

    // Receiver: checks each accepted beat and stalls on a changing pattern.
    always @(posedge i_clk) begin : report_monitor
        tcw_pkg::t_out_beat want;
        logic s;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid === 1'b1 && !out_stall) begin
                reports_seen <= reports_seen + 1;
                if (cursor_report_q.size() == 0) begin
                    flag_mismatch("unexpected result, cursor_position",
                                  32'(out_data.cursor_position), 0);
                end else begin
                    want = cursor_report_q.pop_front();
                    if (out_data.cursor_position !== want.cursor_position)
                        flag_mismatch("cursor_position", 32'(out_data.cursor_position),
                                      32'(want.cursor_position));
                    if (out_data.cursor_column !== want.cursor_column)
                        flag_mismatch("cursor_column", 32'(out_data.cursor_column),
                                      32'(want.cursor_column));
                    if (out_data.cursor_row !== want.cursor_row)
                        flag_mismatch("cursor_row", 32'(out_data.cursor_row),
                                      32'(want.cursor_row));
                    if (out_data.read_char !== want.read_char)
                        flag_mismatch("read_char", 32'(out_data.read_char),
                                      32'(want.read_char));
                    if (out_data.read_attr !== want.read_attr)
                        flag_mismatch("read_attr", 32'(out_data.read_attr),
                                      32'(want.read_attr));
                    if (out_data.escape_pending !== want.escape_pending)
                        flag_mismatch("escape_pending", 32'(out_data.escape_pending),
                                      32'(want.escape_pending));
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       s = 1'b0;
                1:       s = ($urandom_range(0, 2) == 0);
                2:       s = ($urandom_range(0, 3) != 0);
                default: s = (cycle_count % 5 == 1);
            endcase
            out_stall <= s || long_hold;
        end
    end

    // One long receiver hold-off while the sender keeps offering beats.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (!hold_done && !long_hold && keys_taken >= HOLD_AFTER_KEYS) begin
                long_hold <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end else if (long_hold) begin
                if (hold_left == 1) begin
                    long_hold <= 1'b0;
                    hold_done <= 1'b1;
                end
                hold_left <= hold_left - 1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("[text_console_character_writer] ERROR");
        $finish;
    end

    initial begin : stimulus
        int i;
        int unsigned pick;
        int unsigned lf_left;
        int unsigned ff_left;
        int unsigned first_random;
        logic [7:0] ch;
        logic [7:0] cmd;

        for (i = 0; i < CELL_COUNT; i++) begin
            screen_copy[tcw_pkg::t_cell_idx'(i)] = {tcw_pkg::ATTR_RESET, tcw_pkg::CHAR_SPACE};
        end
        cur_col = 0;
        cur_row = 0;
        cur_attr = tcw_pkg::ATTR_RESET;
        esc_ph = tcw_pkg::ESC_IDLE;
        esc_cmd = tcw_pkg::CMD_END;

        push_read(tcw_pkg::t_cell_idx'(0));
        push_read(tcw_pkg::t_cell_idx'(2047));
        push_put(tcw_pkg::CHAR_BS);
        push_put(8'h41);
        push_escape(tcw_pkg::CMD_ATTR, 8'h1e);
        push_put(8'hff);
        push_put(8'h00);
        push_escape(tcw_pkg::CMD_END, 8'h00);
        push_put(8'h42);
        push_escape(tcw_pkg::CMD_COLUMN, 8'd200);
        push_escape(tcw_pkg::CMD_ROW, 8'd255);
        push_put(tcw_pkg::CHAR_LF);
        push_put(8'h43);
        push_escape(8'd7, 8'h55);
        push_put(tcw_pkg::CHAR_CR);
        push_put(tcw_pkg::CHAR_BS);
        push_read(tcw_pkg::t_cell_idx'(CELL_COUNT - COLS));
        push_put(tcw_pkg::CHAR_FF);
        push_read(tcw_pkg::t_cell_idx'(CELL_COUNT - 1));

        first_random = keystroke_q.size();
        lf_left = 40;
        ff_left = 6;
        while (keystroke_q.size() < first_random + RANDOM_KEYS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                do begin
                    ch = 8'($urandom_range(0, 255));
                end while (ch == tcw_pkg::CHAR_FF || ch == tcw_pkg::CHAR_CR ||
                           ch == tcw_pkg::CHAR_BS || ch == tcw_pkg::CHAR_LF ||
                           ch == tcw_pkg::CHAR_ESC);
                push_put(ch);
            end else if (pick < 63) begin
                if ($urandom_range(0, 9) < 8)
                    push_read(tcw_pkg::t_cell_idx'($urandom_range(0, CELL_COUNT - 1)));
                else
                    push_read(tcw_pkg::t_cell_idx'($urandom_range(CELL_COUNT, 2047)));
            end else if (pick < 77) begin
                case ($urandom_range(0, 9))
                    0: push_escape(tcw_pkg::CMD_END, 8'h00);
                    1, 2: push_escape(tcw_pkg::CMD_ATTR, 8'($urandom_range(0, 255)));
                    3, 4: push_escape(tcw_pkg::CMD_COLUMN, $urandom_range(0, 1) ?
                                      8'($urandom_range(0, COLS - 1)) :
                                      8'($urandom_range(0, 255)));
                    5, 6: push_escape(tcw_pkg::CMD_ROW, $urandom_range(0, 1) ?
                                      8'($urandom_range(0, ROWS_N - 1)) :
                                      8'($urandom_range(0, 255)));
                    7: push_escape(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    8: push_put(tcw_pkg::CHAR_ESC);
                    default: begin
                        cmd = 8'($urandom_range(1, 3));
                        push_put(tcw_pkg::CHAR_ESC);
                        push_read(tcw_pkg::t_cell_idx'($urandom_range(0, 2047)));
                        push_put(cmd);
                        push_read(tcw_pkg::t_cell_idx'($urandom_range(0, 2047)));
                        push_put(8'($urandom_range(0, 255)));
                    end
                endcase
            end else if (pick < 84) begin
                push_put(tcw_pkg::CHAR_CR);
            end else if (pick < 91) begin
                push_put(tcw_pkg::CHAR_BS);
            end else if (pick < 98 && lf_left != 0) begin
                push_put(tcw_pkg::CHAR_LF);
                lf_left--;
            end else if (pick >= 98 && ff_left != 0) begin
                push_put(tcw_pkg::CHAR_FF);
                ff_left--;
            end else begin
                push_put(tcw_pkg::CHAR_CR);
            end
        end
        keystroke_q[first_random].drain_first = 1'b1;
        keystroke_q[first_random + RANDOM_KEYS / 2].drain_first = 1'b1;
        total_keys = keystroke_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reports_seen < total_keys) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cursor_report_q.size() != 0)
            flag_mismatch("expected results left over", 32'(cursor_report_q.size()), 0);

        $display("Run covered %0d console beats: %0d cell reads, %0d escapes, %0d scrolls,",
                 total_keys, read_cnt, esc_cnt, scroll_cnt);
        $display("%0d screen clears and a %0d-cycle result hold-off, in %0d cycles.",
                 clear_cnt, HOLD_CYCLES, cycle_count);
        if (mismatch_cnt == 0) begin
            $display("[text_console_character_writer] OK");
        end else begin
            $display("[text_console_character_writer] ERROR");
        end
        $finish;
    end

endmodule
